// ----- rtl/wfd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// Holds parse phase enum, result kinds, error codes and the result item struct.
// No dependencies.
`timescale 1ns / 1ps

package wfd_pkg;

  // Default width of the per-message byte counter
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Reset value of the message size limit register
  localparam logic [31:0] MAX_MSG_RESET = 32'd65536;

  // Header field masks and length escape codes
  localparam logic [7:0] HDR_BIT7_MASK = 8'h80;
  localparam logic [7:0] OPCODE_MASK   = 8'h0F;
  localparam logic [7:0] LEN7_MASK     = 8'h7F;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_EXT64     = 7'd127;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [1:0] MASK_LAST_POS = 2'd3;

  // Opcodes of interest
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Parse phase
  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_RESERVED = 2'd1,
    ERR_ORDER    = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  // One result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [3:0] message_opcode;
    logic       frame_final;
    logic       frame_end;
    logic       message_end;
    err_e       error_code;
  } result_t;

endpackage

// ----- rtl/wfd_parser.sv -----
// Frame header parser and payload unmasker: parse state, limit register and
// per-byte decode producing at most one result item. Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_parser #(
  parameter int unsigned COUNT_WIDTH = wfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output logic             res_valid_o,
  output wfd_pkg::result_t res_o
);

  localparam logic [64:0] CountMax = (65'd1 << COUNT_WIDTH) - 65'd1;

  wfd_pkg::phase_e        phase_q, phase_d;
  logic                   fin_q, fin_d;
  logic [3:0]             op_q, op_d;
  logic                   mask_q, mask_d;
  logic [3:0]             ext_left_q, ext_left_d;
  logic [63:0]            rem_q, rem_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             pos_q, pos_d;
  logic                   open_q, open_d;
  logic [3:0]             open_op_q, open_op_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [31:0]            limit_q;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wfd_pkg::MAX_MSG_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wfd_pkg::PH_HDR1;
      fin_q      <= 1'b0;
      op_q       <= '0;
      mask_q     <= 1'b0;
      ext_left_q <= '0;
      rem_q      <= '0;
      key_q      <= '0;
      pos_q      <= '0;
      open_q     <= 1'b0;
      open_op_q  <= '0;
      count_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      op_q       <= op_d;
      mask_q     <= mask_d;
      ext_left_q <= ext_left_d;
      rem_q      <= rem_d;
      key_q      <= key_d;
      pos_q      <= pos_d;
      open_q     <= open_d;
      open_op_q  <= open_op_d;
      count_q    <= count_d;
    end
  end

  logic        len_done;
  logic        end_empty;
  logic        close_frame;
  logic        err;
  wfd_pkg::err_e err_code;
  logic        pay_out;
  logic        pay_fend;
  logic [7:0]  pay_byte;
  logic [7:0]  key_byte;
  logic        ctrl;
  logic [3:0]  shown_op;
  logic [63:0] base;
  logic [64:0] sum;
  logic        too_long;
  logic [6:0]  len7;

  // Key byte for the current payload position, most significant first
  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign len7 = rx_byte_i[6:0] & wfd_pkg::LEN7_MASK[6:0];

  // Length check: message count plus frame length against the limit
  assign ctrl     = op_d[3];
  assign shown_op = ctrl ? op_d : open_op_q;
  assign base     = ctrl ? 64'd0 : 64'(count_q);
  assign sum      = {1'b0, base} + {1'b0, rem_d};
  assign too_long = sum > {33'd0, limit_q};

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    op_d       = op_q;
    mask_d     = mask_q;
    ext_left_d = ext_left_q;
    rem_d      = rem_q;
    key_d      = key_q;
    pos_d      = pos_q;
    open_d     = open_q;
    open_op_d  = open_op_q;
    count_d    = count_q;
    len_done    = 1'b0;
    end_empty   = 1'b0;
    close_frame = 1'b0;
    err         = 1'b0;
    err_code    = wfd_pkg::ERR_NONE;
    pay_out     = 1'b0;
    pay_fend    = 1'b0;
    pay_byte    = '0;

    if (step_i) begin
      unique case (phase_q)
        wfd_pkg::PH_HDR1: begin
          fin_d = (rx_byte_i & wfd_pkg::HDR_BIT7_MASK) != 8'd0;
          op_d  = rx_byte_i[3:0] & wfd_pkg::OPCODE_MASK[3:0];
          key_d = '0;
          pos_d = '0;
          rem_d = '0;
          if ((op_d >= 4'd3 && op_d <= 4'd7) || op_d >= 4'd11) begin
            err      = 1'b1;
            err_code = wfd_pkg::ERR_RESERVED;
          end else if (op_d == wfd_pkg::OP_CONT && !open_q) begin
            err      = 1'b1;
            err_code = wfd_pkg::ERR_ORDER;
          end else if ((op_d == wfd_pkg::OP_TEXT || op_d == wfd_pkg::OP_BINARY) && open_q) begin
            err      = 1'b1;
            err_code = wfd_pkg::ERR_ORDER;
          end else begin
            if (op_d == wfd_pkg::OP_TEXT || op_d == wfd_pkg::OP_BINARY) begin
              open_op_d = op_d;
              count_d   = '0;
            end
            phase_d = wfd_pkg::PH_HDR2;
          end
        end
        wfd_pkg::PH_HDR2: begin
          mask_d = (rx_byte_i & wfd_pkg::HDR_BIT7_MASK) != 8'd0;
          if (len7 == wfd_pkg::LEN_EXT16) begin
            ext_left_d = wfd_pkg::EXT16_BYTES;
            phase_d    = wfd_pkg::PH_EXTLEN;
          end else if (len7 == wfd_pkg::LEN_EXT64) begin
            ext_left_d = wfd_pkg::EXT64_BYTES;
            phase_d    = wfd_pkg::PH_EXTLEN;
          end else begin
            rem_d    = {57'd0, len7};
            len_done = 1'b1;
          end
        end
        wfd_pkg::PH_EXTLEN: begin
          rem_d      = {rem_q[55:0], rx_byte_i};
          ext_left_d = ext_left_q - 4'd1;
          len_done   = (ext_left_d == 4'd0);
        end
        wfd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          pos_d = pos_q + 2'd1;
          if (pos_q == wfd_pkg::MASK_LAST_POS) begin
            if (rem_q == 64'd0) begin
              end_empty = 1'b1;
            end else begin
              phase_d = wfd_pkg::PH_PAYLOAD;
            end
          end
        end
        wfd_pkg::PH_PAYLOAD: begin
          pos_d       = pos_q + 2'd1;
          rem_d       = rem_q - 64'd1;
          pay_out     = 1'b1;
          pay_byte    = rx_byte_i ^ key_byte;
          pay_fend    = (rem_q == 64'd1);
          close_frame = pay_fend;
        end
        wfd_pkg::PH_ERROR: begin
          // latched: bytes are taken and dropped
        end
        default: begin
          phase_d = wfd_pkg::PH_ERROR;
        end
      endcase

      // Full length known
      if (len_done) begin
        if (too_long) begin
          err      = 1'b1;
          err_code = wfd_pkg::ERR_TOO_LONG;
        end else begin
          if (!ctrl) begin
            count_d = (sum > CountMax) ? '1 : sum[COUNT_WIDTH-1:0];
          end
          if (mask_d) begin
            phase_d = wfd_pkg::PH_MASK;
            pos_d   = '0;
          end else if (rem_d == 64'd0) begin
            end_empty = 1'b1;
          end else begin
            phase_d = wfd_pkg::PH_PAYLOAD;
          end
        end
      end

      if (end_empty) begin
        close_frame = 1'b1;
      end

      // Frame end: a FIN data frame closes its message
      if (close_frame) begin
        if (!ctrl) begin
          if (fin_q) begin
            open_d  = 1'b0;
            count_d = '0;
          end else begin
            open_d = 1'b1;
          end
        end
        phase_d = wfd_pkg::PH_HDR1;
      end

      if (err) begin
        phase_d = wfd_pkg::PH_ERROR;
      end
    end
  end

  // Result item
  always_comb begin
    res_o             = '0;
    res_o.frame_final = fin_d;
    res_valid_o       = 1'b0;
    if (err) begin
      res_valid_o          = 1'b1;
      res_o.kind           = wfd_pkg::KIND_ERROR;
      res_o.message_opcode = op_d;
      res_o.error_code     = err_code;
    end else if (end_empty) begin
      res_valid_o          = 1'b1;
      res_o.kind           = wfd_pkg::KIND_EMPTY;
      res_o.message_opcode = shown_op;
      res_o.frame_end      = 1'b1;
      res_o.message_end    = fin_q;
    end else if (pay_out) begin
      res_valid_o          = 1'b1;
      res_o.kind           = wfd_pkg::KIND_PAYLOAD;
      res_o.payload_byte   = pay_byte;
      res_o.message_opcode = shown_op;
      res_o.frame_end      = pay_fend;
      res_o.message_end    = pay_fend & fin_q;
    end
  end

endmodule

// ----- rtl/wfd_out_buf.sv -----
// Two-entry output buffer: result register plus skid register, so a new
// item can be taken while a result waits. Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wfd_pkg::result_t data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wfd_pkg::result_t out_o
);

  logic             main_valid_q;
  logic             skid_valid_q;
  wfd_pkg::result_t main_q;
  wfd_pkg::result_t skid_q;
  logic             pop;
  logic             main_load;
  logic             skid_load;

  assign pop       = main_valid_q & out_ready_i;
  assign main_load = !main_valid_q || pop;
  assign skid_load = main_valid_q && !pop && push_i;
  assign space_o   = !skid_valid_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (main_load) begin
        main_valid_q <= skid_valid_q | push_i;
        skid_valid_q <= 1'b0;
      end else if (skid_load) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (main_load) begin
      main_q <= skid_valid_q ? skid_q : data_i;
    end
    if (skid_load) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

endmodule

// ----- rtl/websocket_frame_deframer_unit.sv -----
// WebSocket frame deframer: one received byte per item, unmasked payload out.
// Each result is registered; a skid register keeps input going while one waits.
// Throughput: one byte per cycle while the skid register is free; the parse
// state updates in a single pass.
// Reset (async, active low) returns to the first header byte, clears the error
// latch and message state, and sets the message limit to 65536.
`timescale 1ns / 1ps

module websocket_frame_deframer_unit #(
  parameter int unsigned COUNT_WIDTH = wfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  message_opcode_o,
  output logic        frame_final_o,
  output logic        frame_end_o,
  output logic        message_end_o,
  output logic [1:0]  error_code_o
);

  logic             step;
  logic             res_valid;
  logic             space;
  wfd_pkg::result_t res;
  wfd_pkg::result_t out;

  assign in_ready_o = space;
  assign step       = in_valid_i & space;

  // Header parse and unmask
  wfd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result buffering
  wfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign kind_o           = out.kind;
  assign payload_byte_o   = out.payload_byte;
  assign message_opcode_o = out.message_opcode;
  assign frame_final_o    = out.frame_final;
  assign frame_end_o      = out.frame_end;
  assign message_end_o    = out.message_end;
  assign error_code_o     = out.error_code;

endmodule

// ----- verif/wfd_checker.sv -----
// Checker for the WebSocket frame deframer: watches both item channels, tracks
// the parse state itself and compares each result item field by field.
// Depends on wfd_pkg for the result struct, phase, kind, error and opcode names.
`timescale 1ns / 1ps

module wfd_checker
  import wfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [3:0]  message_opcode_i,
  input  logic        frame_final_i,
  input  logic        frame_end_i,
  input  logic        message_end_i,
  input  logic [1:0]  error_code_i,
  output int          pending_o,
  output int          fail_count_o
);

  // Parser state as seen from the stream
  phase_e                     ph;
  logic                       fin_q;
  logic [3:0]                 op_q;
  logic                       masked_q;
  logic [3:0]                 ext_left;
  logic [63:0]                rem_len;
  logic [31:0]                key_q;
  logic [1:0]                 key_pos;
  logic                       msg_open;
  logic [3:0]                 msg_op;
  logic [COUNT_WIDTH_DEF-1:0] msg_count;
  logic                       err_seen;
  logic [31:0]                max_bytes;

  result_t deframed_q[$];
  int      mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  // One line per mismatch; printing capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic result_t make_result(input kind_e k, input logic [7:0] d,
                                          input logic [3:0] opc, input logic fend,
                                          input logic mend, input err_e e);
    result_t r;
    r.kind           = k;
    r.payload_byte   = d;
    r.message_opcode = opc;
    r.frame_final    = fin_q;
    r.frame_end      = fend;
    r.message_end    = mend;
    r.error_code     = e;
    return r;
  endfunction

  // Control frames show their own opcode, data frames that of the open message
  function automatic logic [3:0] shown_op();
    return (op_q >= OP_CLOSE) ? op_q : msg_op;
  endfunction

  function automatic bit raise_err(input err_e code, output result_t r);
    err_seen = 1'b1;
    ph       = PH_ERROR;
    r        = make_result(KIND_ERROR, 8'd0, op_q, 1'b0, 1'b0, code);
    return 1'b1;
  endfunction

  // End of frame: a FIN data frame closes the message, a non-FIN one opens it
  function automatic void close_frame();
    if (op_q < OP_CLOSE) begin
      if (fin_q) begin
        msg_open  = 1'b0;
        msg_count = '0;
      end else begin
        msg_open = 1'b1;
      end
    end
    ph = PH_HDR1;
  endfunction

  function automatic bit end_empty(output result_t r);
    logic [3:0] opc;
    logic       mend;
    opc  = shown_op();
    mend = fin_q;
    close_frame();
    r = make_result(KIND_EMPTY, 8'd0, opc, 1'b1, mend, ERR_NONE);
    return 1'b1;
  endfunction

  // Full length known: limit check, count update, then mask key or payload
  function automatic bit length_known(output result_t r);
    logic [63:0] base;
    logic [63:0] lim;
    logic [63:0] sum;
    r    = '0;
    base = (op_q >= OP_CLOSE) ? 64'd0 : 64'(msg_count);
    lim  = 64'(max_bytes);
    if (base > lim || rem_len > lim - base)
      return raise_err(ERR_TOO_LONG, r);
    if (op_q < OP_CLOSE) begin
      sum = base + rem_len;
      if ((sum >> COUNT_WIDTH_DEF) != 64'd0)
        msg_count = '1;
      else
        msg_count = sum[COUNT_WIDTH_DEF-1:0];
    end
    if (masked_q) begin
      ph      = PH_MASK;
      key_pos = '0;
      return 1'b0;
    end
    if (rem_len == 64'd0)
      return end_empty(r);
    ph = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advance the parse by one stream byte; returns 1 when a result item is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [3:0] opc;
    logic [7:0] d;
    logic       fend;
    logic       mend;
    r = '0;
    if (err_seen || ph == PH_ERROR)
      return 1'b0;
    case (ph)
      PH_HDR1: begin
        fin_q   = b[7];
        op_q    = b[3:0];
        key_q   = '0;
        key_pos = '0;
        rem_len = '0;
        if (!(op_q inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
          return raise_err(ERR_RESERVED, r);
        if (op_q == OP_CONT && !msg_open)
          return raise_err(ERR_ORDER, r);
        if ((op_q == OP_TEXT || op_q == OP_BINARY) && msg_open)
          return raise_err(ERR_ORDER, r);
        if (op_q == OP_TEXT || op_q == OP_BINARY) begin
          msg_op    = op_q;
          msg_count = '0;
        end
        ph = PH_HDR2;
        return 1'b0;
      end
      PH_HDR2: begin
        masked_q = b[7];
        if (b[6:0] == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          ph       = PH_EXTLEN;
          return 1'b0;
        end
        if (b[6:0] == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          ph       = PH_EXTLEN;
          return 1'b0;
        end
        rem_len = 64'(b[6:0]);
        return length_known(r);
      end
      PH_EXTLEN: begin
        // big-endian: shift the running length up a byte
        rem_len  = {rem_len[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0)
          return length_known(r);
        return 1'b0;
      end
      PH_MASK: begin
        key_q   = {key_q[23:0], b};
        key_pos = key_pos + 2'd1;
        if (key_pos == 2'd0) begin
          if (rem_len == 64'd0)
            return end_empty(r);
          ph = PH_PAYLOAD;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        opc     = shown_op();
        d       = b ^ key_q[8 * (3 - int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        rem_len = rem_len - 64'd1;
        fend    = (rem_len == 64'd0);
        mend    = fend & fin_q;
        if (fend)
          close_frame();
        r = make_result(KIND_PAYLOAD, d, opc, fend, mend, ERR_NONE);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  // Results first (they can only belong to earlier items), then config, then input
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      ph        = PH_HDR1;
      fin_q     = 1'b0;
      op_q      = OP_CONT;
      masked_q  = 1'b0;
      ext_left  = '0;
      rem_len   = '0;
      key_q     = '0;
      key_pos   = '0;
      msg_open  = 1'b0;
      msg_op    = OP_CONT;
      msg_count = '0;
      err_seen  = 1'b0;
      max_bytes = MAX_MSG_RESET;
      deframed_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (deframed_q.size() == 0) begin
          report_mismatch("result with nothing expected", {6'd0, kind_i}, 8'd0);
        end else begin
          want = deframed_q.pop_front();
          if (kind_i !== want.kind)
            report_mismatch("kind", {6'd0, kind_i}, {6'd0, want.kind});
          if (payload_byte_i !== want.payload_byte)
            report_mismatch("payload_byte", payload_byte_i, want.payload_byte);
          if (message_opcode_i !== want.message_opcode)
            report_mismatch("message_opcode", {4'd0, message_opcode_i},
                            {4'd0, want.message_opcode});
          if (frame_final_i !== want.frame_final)
            report_mismatch("frame_final", {7'd0, frame_final_i}, {7'd0, want.frame_final});
          if (frame_end_i !== want.frame_end)
            report_mismatch("frame_end", {7'd0, frame_end_i}, {7'd0, want.frame_end});
          if (message_end_i !== want.message_end)
            report_mismatch("message_end", {7'd0, message_end_i}, {7'd0, want.message_end});
          if (error_code_i !== want.error_code)
            report_mismatch("error_code", {6'd0, error_code_i}, {6'd0, want.error_code});
        end
      end
      if (cfg_we_i)
        max_bytes = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(rx_byte_i, want))
          deframed_q.push_back(want);
      end
      pending_o <= deframed_q.size();
    end
  end

endmodule

// ----- verif/tb_websocket_frame_deframer_unit.sv -----
// Top of the deframer testbench: clock, reset, frame stream generation and the
// verdict. Depends on wfd_pkg, websocket_frame_deframer_unit and wfd_checker.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;
  import wfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {LF_SHORT, LF_EXT16, LF_EXT64} len_form_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [3:0]  message_opcode_o;
  logic        frame_final_o;
  logic        frame_end_o;
  logic        message_end_o;
  logic [1:0]  error_code_o;

  int pending;
  int fail_count;
  int cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int sent_bytes = 0;

  // Message bookkeeping so that random frames stay well formed
  bit          msg_open = 1'b0;
  logic [63:0] msg_used = '0;

  logic [7:0] opening_bytes[$];

  websocket_frame_deframer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .message_opcode_o (message_opcode_o),
    .frame_final_o    (frame_final_o),
    .frame_end_o      (frame_end_o),
    .message_end_o    (message_end_o),
    .error_code_o     (error_code_o)
  );

  wfd_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_i           (kind_o),
    .payload_byte_i   (payload_byte_o),
    .message_opcode_i (message_opcode_o),
    .frame_final_i    (frame_final_o),
    .frame_end_i      (frame_end_o),
    .message_end_i    (message_end_o),
    .error_code_i     (error_code_o),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_websocket_frame_deframer_unit: done, errors");
      $finish;
    end
  end

  // Offer one stream byte, with random gaps before it, and wait until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  // Hold the stream until every expected result item has come, then a short pause
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || out_valid_o);
    repeat (4) @(posedge clk_i);
  endtask

  // One whole frame: header, the given length in a random encoding, optional key, payload
  task automatic send_frame(input bit fin, input logic [3:0] opc, input logic [63:0] len);
    bit          masked;
    logic [31:0] key;
    len_form_e   form;
    int          r;
    masked = $urandom_range(0, 1);
    key    = $urandom();
    r      = $urandom_range(0, 9);
    if (len > 64'd125)
      form = (r < 5) ? LF_EXT16 : LF_EXT64;
    else
      form = (r < 8) ? LF_SHORT : ((r == 8) ? LF_EXT16 : LF_EXT64);
    // reserved bits are random; the block ignores them
    send_byte({fin, 3'($urandom_range(0, 7)), opc});
    case (form)
      LF_SHORT: send_byte({masked, len[6:0]});
      LF_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int n = 0; n < int'(len); n++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // One setting of the limit: random well-formed messages with control frames mixed in
  task automatic run_phase(input logic [31:0] lim, input int in_pct, input int out_pct,
                           input int n_bytes);
    int          stop_at;
    int          frames;
    int          r;
    logic [63:0] room;
    logic [63:0] len;
    logic [3:0]  opc;
    bit          fin;
    bit          is_ctrl;
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = sent_bytes + n_bytes;
    frames       = 0;
    while (sent_bytes < stop_at || msg_open) begin
      if (frames == 5 || $urandom_range(0, 29) == 0)
        wait_idle();
      is_ctrl = ($urandom_range(0, 4) == 0);
      if (is_ctrl) begin
        case ($urandom_range(0, 2))
          0:       opc = OP_CLOSE;
          1:       opc = OP_PING;
          default: opc = OP_PONG;
        endcase
        fin  = ($urandom_range(0, 5) != 0);
        room = 64'(lim);
      end else begin
        if (!msg_open) begin
          opc      = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
          msg_used = '0;
        end else begin
          opc = OP_CONT;
        end
        fin  = (sent_bytes >= stop_at) || ($urandom_range(0, 9) < 6);
        room = 64'(lim) - msg_used;
      end
      // mostly short frames, some past the 7-bit escape, some filling the limit exactly
      r = $urandom_range(0, 99);
      if (r < 55)
        len = 64'($urandom_range(0, 8));
      else if (r < 85)
        len = 64'($urandom_range(9, 40));
      else if (r < 95)
        len = 64'($urandom_range(100, 140));
      else
        len = (room <= 64'd140) ? room : 64'd126;
      if (len > room)
        len = room;
      send_frame(fin, opc, len);
      if (!is_ctrl) begin
        msg_used = msg_used + len;
        msg_open = !fin;
        if (fin)
          msg_used = '0;
      end
      frames++;
    end
  endtask

  initial begin : stimulus
    logic [3:0] ropc;
    bit         fin;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 22;
    out_idle_pct = 68;

    // Directed opening: byte extremes, each opcode, empty frames, all-ones key,
    // 16-bit length, a control frame inside a fragmented message, reserved bits set
    opening_bytes = '{
      {1'b1, 3'b000, OP_TEXT},   8'h01, 8'hFF,
      {1'b0, 3'b000, OP_BINARY}, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      {1'b1, 3'b000, OP_PING},   8'h00,
      {1'b1, 3'b000, OP_CONT},   {1'b0, LEN_EXT16}, 8'h00, 8'h02, 8'h00, 8'h5A,
      {1'b1, 3'b111, OP_CLOSE},  8'h00,
      {1'b1, 3'b000, OP_PONG},   8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hED
    };
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    run_phase(32'hFFFF_FFFF, 22, 68, 350);
    run_phase(32'd0, 22, 68, 100);
    run_phase(32'd24, 68, 22, 350);
    run_phase(32'($urandom_range(1, 200)), 68, 22, 350);
    run_phase(MAX_MSG_RESET, 0, 0, 300);

    // Closing fault: the error latches for the rest of the run, so only one is possible
    fin = $urandom_range(0, 1);
    case ($urandom_range(0, 2))
      0: begin
        do ropc = 4'($urandom_range(0, 15));
        while (ropc inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
        send_byte({fin, 3'($urandom_range(0, 7)), ropc});
      end
      1: begin
        if ($urandom_range(0, 1)) begin
          // continuation with no message open
          send_byte({fin, 3'b000, OP_CONT});
        end else begin
          // open a message with an empty fragment, then start a new one
          send_byte({1'b0, 3'b000, OP_TEXT});
          send_byte(8'h00);
          send_byte({fin, 3'b000, ($urandom_range(0, 1) ? OP_TEXT : OP_BINARY)});
        end
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       ropc = OP_TEXT;
          1:       ropc = OP_BINARY;
          default: ropc = OP_PING;
        endcase
        send_byte({1'b1, 3'b000, ropc});
        send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
        if ($urandom_range(0, 1)) begin
          // top bit of the 64-bit length set
          send_byte({1'b1, 7'($urandom_range(0, 127))});
          for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 255)));
        end else begin
          // one byte over the limit
          for (int i = 7; i >= 0; i--) send_byte(8'((64'(MAX_MSG_RESET) + 64'd1) >> (8 * i)));
        end
      end
    endcase
    // the block must stay silent from here on
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)));

    wait_idle();
    if (fail_count == 0)
      $display("tb_websocket_frame_deframer_unit: done, clean");
    else
      $display("tb_websocket_frame_deframer_unit: done, errors");
    $finish;
  end

endmodule
